// File: src/assert_macros.svh
// Assertion macros shared by the incline estimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BFRI_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition is followed by another on the next clock edge.
`define BFRI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/bfri_pkg.sv
// Types, constants and the arctangent table of the incline estimator.
`default_nettype none

package bfri_pkg;

  localparam int MUL_W      = 64;
  localparam int PROD_W     = 128;
  localparam int Q_W        = 25;
  localparam int Q_MSB      = 24;
  localparam int Z_W        = 27;
  localparam int CORD_LAST  = 23;
  localparam int NORM_TOP   = 59;
  localparam int ROUND_ADD  = 1024;
  localparam int ANGLE_LSB  = 11;
  localparam int ANGLE_W    = 16;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_TAKE,
    OP_ACC,
    OP_MSTART,
    OP_MSAVE,
    OP_CLR_RUN,
    OP_DIV_STEP,
    OP_KEEP,
    OP_CORD_LOAD,
    OP_NORM_STEP,
    OP_CORD_STEP,
    OP_OUT
  } dp_op_t;

  typedef enum logic [2:0] {
    P_N_SXX,
    P_SX_SX,
    P_N_SYY,
    P_SY_SY,
    P_N_SXY,
    P_SX_SY,
    P_COV_SQ,
    P_VAR_PROD
  } prod_sel_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACC,
    S_DECIDE,
    S_MSTART,
    S_MWAIT,
    S_MSAVE,
    S_CHECK,
    S_DIV,
    S_KEEP,
    S_POST,
    S_FIN,
    S_NORM,
    S_CORD,
    S_OUT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t    op;
    prod_sel_t sel;
  } dp_cmd_t;

  typedef struct packed {
    logic run_empty;
    logic box_sep;
    logic box_last;
    logic mul_busy;
    logic var_zero;
    logic div_last;
    logic norm_done;
    logic cord_last;
    logic have_best;
    logic out_free;
  } dp_status_t;

  // atan(2^-i) with 24 fraction bits
  function automatic logic [Z_W-1:0] atan_step(input logic [4:0] idx);
    logic [Z_W-1:0] v;
    case (idx)
      5'd0:  v = Z_W'(13176795);
      5'd1:  v = Z_W'(7778716);
      5'd2:  v = Z_W'(4110060);
      5'd3:  v = Z_W'(2086331);
      5'd4:  v = Z_W'(1047214);
      5'd5:  v = Z_W'(524117);
      5'd6:  v = Z_W'(262123);
      5'd7:  v = Z_W'(131069);
      5'd8:  v = Z_W'(65536);
      5'd9:  v = Z_W'(32768);
      5'd10: v = Z_W'(16384);
      5'd11: v = Z_W'(8192);
      5'd12: v = Z_W'(4096);
      5'd13: v = Z_W'(2048);
      5'd14: v = Z_W'(1024);
      5'd15: v = Z_W'(512);
      5'd16: v = Z_W'(256);
      5'd17: v = Z_W'(128);
      5'd18: v = Z_W'(64);
      5'd19: v = Z_W'(32);
      5'd20: v = Z_W'(16);
      5'd21: v = Z_W'(8);
      5'd22: v = Z_W'(4);
      5'd23: v = Z_W'(2);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/bfri_mul.sv
// Shift-and-add 64 x 64 unsigned multiplier, one multiplier bit per cycle.
`default_nettype none

module bfri_mul (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [bfri_pkg::MUL_W-1:0] a,
  input  wire logic [bfri_pkg::MUL_W-1:0] b,
  output logic                            busy,
  output logic [bfri_pkg::PROD_W-1:0]     prod
);
  import bfri_pkg::*;

  localparam int CNT_W = $clog2(MUL_W + 1);

  logic [CNT_W-1:0] cnt;
  logic [MUL_W-1:0] mcand;
  logic [MUL_W-1:0] hi;
  logic [MUL_W-1:0] lo;
  logic [MUL_W:0]   sum;

  // add the multiplicand when the current multiplier bit is set
  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign busy = (cnt != '0);
  assign prod = {hi, lo};

  // count the steps
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= CNT_W'(MUL_W);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end
  end

  // load operands, then shift the partial product right
  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= b;
    end else if (busy) begin
      hi <= sum[MUL_W:1];
      lo <= {sum[0], lo[MUL_W-1:1]};
    end
  end

endmodule

`default_nettype wire

// File: src/bfri_dp.sv
// Datapath: run sums, variance products, correlation divide and CORDIC angle.
`default_nettype none
`include "assert_macros.svh"

module bfri_dp #(
  parameter int MAX_RUN_BOXES = 1024,
  parameter int COORD_BITS    = 12
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire bfri_pkg::dp_cmd_t                 cmd,
  output bfri_pkg::dp_status_t                   status,
  input  wire logic [COORD_BITS-1:0]             box_top,
  input  wire logic [COORD_BITS-1:0]             box_left,
  input  wire logic [COORD_BITS-1:0]             box_height,
  input  wire logic [COORD_BITS-1:0]             box_width,
  input  wire logic                              list_end,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic signed [bfri_pkg::ANGLE_W-1:0]    incline_angle
);
  import bfri_pkg::*;

  localparam int CEN_W = COORD_BITS + 2;
  localparam int CNT_W = $clog2(MAX_RUN_BOXES + 1);
  localparam int SUM_W = CEN_W + CNT_W;
  localparam int SQ_W  = 2 * CEN_W + CNT_W;

  // latched box word
  logic [CEN_W-1:0] cx;
  logic [CEN_W-1:0] cy;
  logic             box_sep;
  logic             box_last;

  // run sums
  logic [CNT_W-1:0] run_count;
  logic [SUM_W-1:0] sum_cx;
  logic [SUM_W-1:0] sum_cy;
  logic [SQ_W-1:0]  sum_cx_sq;
  logic [SQ_W-1:0]  sum_cy_sq;
  logic [SQ_W-1:0]  sum_cx_cy;

  // run end values
  logic [MUL_W-1:0]  tmp;
  logic [MUL_W-1:0]  vx;
  logic [MUL_W-1:0]  vy;
  logic [MUL_W-1:0]  cov;
  logic [MUL_W-1:0]  acov;
  logic [PROD_W-1:0] rem;
  logic [PROD_W-1:0] den;
  logic [PROD_W-1:0] den_sh;
  logic [Q_W-1:0]    q;
  logic [4:0]        bidx;

  // kept run
  logic [Q_W-1:0]   best_corr_sq;
  logic [MUL_W-1:0] best_covariance;
  logic [MUL_W-1:0] best_x_variance;

  // CORDIC
  logic signed [MUL_W-1:0] xr;
  logic signed [MUL_W-1:0] yr;
  logic [MUL_W-1:0]        mr;
  logic [5:0]              sh;
  logic [4:0]              ci;
  logic [Z_W-1:0]          zr;
  logic [Z_W-1:0]          z_round;
  logic signed [MUL_W-1:0] dx;
  logic signed [MUL_W-1:0] dy;

  // products of the box centres
  logic [2*CEN_W-1:0] sq_x;
  logic [2*CEN_W-1:0] sq_y;
  logic [2*CEN_W-1:0] sq_xy;

  // multiplier
  logic              mul_start;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic              mul_busy;
  logic [PROD_W-1:0] prod;

  assign sq_x  = cx * cx;
  assign sq_y  = cy * cy;
  assign sq_xy = cx * cy;

  assign acov    = cov[MUL_W-1] ? (MUL_W'(0) - cov) : cov;
  assign den_sh  = den << bidx;
  assign dx      = yr >>> ci;
  assign dy      = xr >>> ci;
  assign z_round = zr + Z_W'(ROUND_ADD);

  // pick the multiplier operands for each product
  always_comb begin
    case (cmd.sel)
      P_N_SXX:    begin mul_a = MUL_W'(run_count); mul_b = MUL_W'(sum_cx_sq); end
      P_SX_SX:    begin mul_a = MUL_W'(sum_cx);    mul_b = MUL_W'(sum_cx);    end
      P_N_SYY:    begin mul_a = MUL_W'(run_count); mul_b = MUL_W'(sum_cy_sq); end
      P_SY_SY:    begin mul_a = MUL_W'(sum_cy);    mul_b = MUL_W'(sum_cy);    end
      P_N_SXY:    begin mul_a = MUL_W'(run_count); mul_b = MUL_W'(sum_cx_cy); end
      P_SX_SY:    begin mul_a = MUL_W'(sum_cx);    mul_b = MUL_W'(sum_cy);    end
      P_COV_SQ:   begin mul_a = acov;              mul_b = acov;              end
      P_VAR_PROD: begin mul_a = vx;                mul_b = vy;                end
      default:    begin mul_a = '0;                mul_b = '0;                end
    endcase
  end

  assign mul_start = (cmd.op == OP_MSTART);

  bfri_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .busy  (mul_busy),
    .prod  (prod)
  );

  // report to the controller
  always_comb begin
    status.run_empty = (run_count == '0);
    status.box_sep   = box_sep;
    status.box_last  = box_last;
    status.mul_busy  = mul_busy;
    status.var_zero  = (vx == '0) || (vy == '0);
    status.div_last  = (bidx == '0);
    status.norm_done = (mr[MUL_W-1:NORM_TOP] != '0) || (sh == 6'(NORM_TOP));
    status.cord_last = (ci == 5'(CORD_LAST));
    status.have_best = (best_corr_sq != '0);
    status.out_free  = !out_valid || !out_stall;
  end

  // latch the incoming word as doubled centres
  always_ff @(posedge clk) begin
    if (cmd.op == OP_TAKE) begin
      cx       <= {1'b0, box_left, 1'b0} + CEN_W'(box_width);
      cy       <= {1'b0, box_top, 1'b0} + CEN_W'(box_height);
      box_sep  <= (box_height == '0) || (box_width == '0);
      box_last <= list_end;
    end
  end

  // run sums: accumulate, clear at run end and list end
  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= '0;
      sum_cx    <= '0;
      sum_cy    <= '0;
      sum_cx_sq <= '0;
      sum_cy_sq <= '0;
      sum_cx_cy <= '0;
    end else if (cmd.op == OP_ACC) begin
      if (!box_sep && (run_count < CNT_W'(MAX_RUN_BOXES))) begin
        run_count <= run_count + 1'b1;
        sum_cx    <= sum_cx + SUM_W'(cx);
        sum_cy    <= sum_cy + SUM_W'(cy);
        sum_cx_sq <= sum_cx_sq + SQ_W'(sq_x);
        sum_cy_sq <= sum_cy_sq + SQ_W'(sq_y);
        sum_cx_cy <= sum_cx_cy + SQ_W'(sq_xy);
      end
    end else if (cmd.op == OP_CLR_RUN || cmd.op == OP_OUT) begin
      run_count <= '0;
      sum_cx    <= '0;
      sum_cy    <= '0;
      sum_cx_sq <= '0;
      sum_cy_sq <= '0;
      sum_cx_cy <= '0;
    end
  end

  // store products and run the restoring divide
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_MSAVE: begin
        case (cmd.sel)
          P_N_SXX, P_N_SYY, P_N_SXY: tmp <= prod[MUL_W-1:0];
          P_SX_SX:    vx  <= tmp - prod[MUL_W-1:0];
          P_SY_SY:    vy  <= tmp - prod[MUL_W-1:0];
          P_SX_SY:    cov <= tmp - prod[MUL_W-1:0];
          P_COV_SQ:   rem <= prod << Q_MSB;
          P_VAR_PROD: den <= prod;
          default:    tmp <= tmp;
        endcase
      end
      OP_CLR_RUN: begin
        q    <= '0;
        bidx <= 5'(Q_MSB);
      end
      OP_DIV_STEP: begin
        if (den_sh <= rem) begin
          rem     <= rem - den_sh;
          q[bidx] <= 1'b1;
        end
        bidx <= bidx - 1'b1;
      end
      default: begin
        tmp <= tmp;
      end
    endcase
  end

  // keep the best run; reset it after each list
  always_ff @(posedge clk) begin
    if (rst || cmd.op == OP_OUT) begin
      best_corr_sq    <= '0;
      best_covariance <= '0;
      best_x_variance <= MUL_W'(1);
    end else if (cmd.op == OP_KEEP && q > best_corr_sq) begin
      best_corr_sq    <= q;
      best_covariance <= cov;
      best_x_variance <= vx;
    end
  end

  // normalise, then rotate towards the x axis
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_CORD_LOAD: begin
        xr <= best_x_variance;
        yr <= best_covariance;
        mr <= best_x_variance | (best_covariance[MUL_W-1] ?
              (MUL_W'(0) - best_covariance) : best_covariance);
        sh <= '0;
        ci <= '0;
        zr <= '0;
      end
      OP_NORM_STEP: begin
        if (!status.norm_done) begin
          xr <= xr <<< 1;
          yr <= yr <<< 1;
          mr <= mr << 1;
          sh <= sh + 1'b1;
        end
      end
      OP_CORD_STEP: begin
        if (!yr[MUL_W-1]) begin
          xr <= xr + dx;
          yr <= yr - dy;
          zr <= zr + atan_step(ci);
        end else begin
          xr <= xr - dx;
          yr <= yr + dy;
          zr <= zr - atan_step(ci);
        end
        ci <= ci + 1'b1;
      end
      default: begin
        ci <= ci;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.op == OP_OUT) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.op == OP_OUT) begin
      incline_angle <= status.have_best ? z_round[Z_W-1:ANGLE_LSB] : '0;
    end
  end

  `BFRI_ASSERT(a_count_bound, run_count <= CNT_W'(MAX_RUN_BOXES), "run count over limit")
  `BFRI_ASSERT(a_best_var, (best_corr_sq != '0) |-> (best_x_variance != '0), "kept run has zero x variance")
  `BFRI_ASSERT_NEXT(a_keep_grows, cmd.op == OP_KEEP, best_corr_sq >= $past(best_corr_sq), "kept correlation fell")

endmodule

`default_nettype wire

// File: src/bfri_ctrl.sv
// Controller state machine sequencing box intake, run end and angle.
`default_nettype none
`include "assert_macros.svh"

module bfri_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  output bfri_pkg::dp_cmd_t         cmd,
  input  wire bfri_pkg::dp_status_t status
);
  import bfri_pkg::*;

  ctrl_state_t state, state_next;
  prod_sel_t   sel, sel_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= P_N_SXX;
    end else begin
      state <= state_next;
      sel   <= sel_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // next state and commands
  always_comb begin
    state_next = state;
    sel_next   = sel;
    cmd.op     = OP_NONE;
    cmd.sel    = sel;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = OP_TAKE;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.op     = OP_ACC;
        state_next = S_DECIDE;
      end
      S_DECIDE: begin
        if ((status.box_sep || status.box_last) && !status.run_empty) begin
          sel_next   = P_N_SXX;
          state_next = S_MSTART;
        end else if (status.box_last) begin
          state_next = S_FIN;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_MSTART: begin
        cmd.op     = OP_MSTART;
        state_next = S_MWAIT;
      end
      S_MWAIT: begin
        if (!status.mul_busy) begin
          state_next = S_MSAVE;
        end
      end
      S_MSAVE: begin
        cmd.op = OP_MSAVE;
        if (sel == P_VAR_PROD) begin
          state_next = S_CHECK;
        end else begin
          sel_next   = prod_sel_t'(sel + 3'd1);
          state_next = S_MSTART;
        end
      end
      S_CHECK: begin
        cmd.op     = OP_CLR_RUN;
        state_next = status.var_zero ? S_POST : S_DIV;
      end
      S_DIV: begin
        cmd.op = OP_DIV_STEP;
        if (status.div_last) begin
          state_next = S_KEEP;
        end
      end
      S_KEEP: begin
        cmd.op     = OP_KEEP;
        state_next = S_POST;
      end
      S_POST: begin
        state_next = status.box_last ? S_FIN : S_IDLE;
      end
      S_FIN: begin
        cmd.op     = OP_CORD_LOAD;
        state_next = status.have_best ? S_NORM : S_OUT;
      end
      S_NORM: begin
        cmd.op = OP_NORM_STEP;
        if (status.norm_done) begin
          state_next = S_CORD;
        end
      end
      S_CORD: begin
        cmd.op = OP_CORD_STEP;
        if (status.cord_last) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  `BFRI_ASSERT_NEXT(a_mul_starts, cmd.op == OP_MSTART, status.mul_busy, "multiplier did not start")
  `BFRI_ASSERT(a_out_free, (cmd.op == OP_OUT) |-> status.out_free, "result overwrites a waiting word")
  `BFRI_ASSERT(a_div_vars, (state == S_DIV) |-> !status.var_zero, "divide on a zero variance")

endmodule

`default_nettype wire

// File: src/best_fit_run_incline_estimator_core.sv
// Top level of the best-fit run incline estimator.
// Boxes arrive one word at a time; zero height or width closes the current
// run, and list_end closes the list. Each box is latched, summed and then
// decided on. Closing a non-empty run takes eight 64x64 products on a
// one-bit-per-cycle shift-and-add multiplier, then, if neither variance is
// zero, a 25-step restoring divide for the squared correlation. If some run
// was kept, the list end adds up to 59 normalising shifts and 24 CORDIC steps
// before the angle word (signed Q2.13 radians, 0 when no run had a non-zero
// squared correlation) is loaded into the output register. The next list may
// start while that word waits.
`default_nettype none

module best_fit_run_incline_estimator_core #(
  parameter int MAX_RUN_BOXES = 1024,
  parameter int COORD_BITS    = 12
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [COORD_BITS-1:0]           box_top,
  input  wire logic [COORD_BITS-1:0]           box_left,
  input  wire logic [COORD_BITS-1:0]           box_height,
  input  wire logic [COORD_BITS-1:0]           box_width,
  input  wire logic                            list_end,
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic signed [bfri_pkg::ANGLE_W-1:0]  incline_angle
);
  import bfri_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  bfri_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .status   (status)
  );

  bfri_dp #(
    .MAX_RUN_BOXES (MAX_RUN_BOXES),
    .COORD_BITS    (COORD_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .status        (status),
    .box_top       (box_top),
    .box_left      (box_left),
    .box_height    (box_height),
    .box_width     (box_width),
    .list_end      (list_end),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .incline_angle (incline_angle)
  );

endmodule

`default_nettype wire
